FILE: src/param_record_crc32_check_defines.svh
// Assertion macros shared by the record CRC check RTL.
`ifndef PARAM_RECORD_CRC32_CHECK_DEFINES_SVH
`define PARAM_RECORD_CRC32_CHECK_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PRCC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PRCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/prcc_pkg.sv
// Shared types, constants and the byte-wide CRC-32/MPEG-2 update for the record check.
package prcc_pkg;

  localparam int CrcW       = 32;
  localparam int ByteW      = 8;
  localparam int VersionW   = 16;
  localparam int CfgDataW   = 16;
  localparam int ByteShift  = 24;

  localparam logic [CrcW-1:0] CRC_POLY   = 32'h04C1_1DB7;
  localparam logic [CrcW-1:0] CRC_PRESET = 32'hFFFF_FFFF;

  // Item action codes; code 3 is unused and ignored
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_ABSORB = 2'd1,
    ACT_FINISH = 2'd2
  } action_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_EXPECTED_VERSION = 1'b0,
    CFG_BYPASS_CHECK     = 1'b1
  } cfg_idx_t;

  // Control word from the pipeline to the CRC unit
  typedef struct packed {
    logic    fire;
    action_t action;
  } crc_ctl_t;

  // One byte through the MSB-first shift register: a flat xor network
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] data);
    logic [CrcW-1:0] c;
    c = crc ^ ({{(CrcW-ByteW){1'b0}}, data} << ByteShift);
    for (int b = 0; b < ByteW; b++) begin
      if (c[CrcW-1]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: src/prcc_crc_unit.sv
// CRC-32/MPEG-2 running register with preset and byte absorb.
module prcc_crc_unit import prcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crc_ctl_t             ctl,
  input  logic [ByteW-1:0]     data_byte,
  output logic [CrcW-1:0]      crc_q
);

  logic [CrcW-1:0] crc_r;
  logic [CrcW-1:0] crc_nxt;

  // Next register value; finish presets after the value is sampled
  always_comb begin
    crc_nxt = crc_r;
    if (ctl.fire) begin
      case (ctl.action)
        ACT_CLEAR:  crc_nxt = CRC_PRESET;
        ACT_ABSORB: crc_nxt = crc_byte(crc_r, data_byte);
        ACT_FINISH: crc_nxt = CRC_PRESET;
        default:    crc_nxt = crc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_PRESET;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc_q = crc_r;

endmodule

FILE: src/param_record_crc32_check.sv
// Top level of the settings record CRC-32/MPEG-2 check.
// Record check: one word per cycle enters; clear and absorb words update the
// CRC register and give no result, a finish word gives one result through the
// input register, then the output register, and presets the CRC. Throughput is
// one word per clock unless a finish word is stalled, set by the byte-wide CRC
// xor network between the input and CRC registers. A held result stalls only
// finish words; clear and absorb words keep flowing past it. Action code 3 is
// dropped. Configuration is a plain write port and must be written while idle.
`include "param_record_crc32_check_defines.svh"
module param_record_crc32_check import prcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input word channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [ByteW-1:0]     in_data_byte,
  input  logic [CrcW-1:0]      in_stored_crc,
  input  logic [VersionW-1:0]  in_stored_version,
  // result word channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CrcW-1:0]      out_crc_value,
  output logic                 out_version_ok,
  output logic                 out_crc_ok,
  output logic                 out_record_valid,
  // configuration writes
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata
);

  // Configuration registers
  logic [VersionW-1:0] exp_version_r;
  logic                bypass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_version_r <= '0;
      bypass_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_EXPECTED_VERSION: exp_version_r <= cfg_wdata[VersionW-1:0];
        CFG_BYPASS_CHECK:     bypass_r      <= cfg_wdata[0];
        default:              ;
      endcase
    end
  end

  // Input register stage
  logic                s1_valid_r;
  logic                s1_valid_nxt;
  logic [1:0]          s1_action_r;
  logic [ByteW-1:0]    s1_data_r;
  logic [CrcW-1:0]     s1_crc_r;
  logic [VersionW-1:0] s1_ver_r;

  logic out_valid_r;
  logic out_valid_nxt;
  logic out_free;
  logic s1_is_finish;
  logic s1_fire;
  logic in_fire;

  assign out_free     = !out_valid_r || out_ready;
  assign s1_is_finish = (action_t'(s1_action_r) == ACT_FINISH);
  assign s1_fire      = s1_valid_r && (!s1_is_finish || out_free);
  assign in_ready     = !s1_valid_r || s1_fire;
  assign in_fire      = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= in_action;
      s1_data_r   <= in_data_byte;
      s1_crc_r    <= in_stored_crc;
      s1_ver_r    <= in_stored_version;
    end
  end

  // CRC register and update
  crc_ctl_t        crc_ctl;
  logic [CrcW-1:0] crc_q;

  assign crc_ctl.fire   = s1_fire;
  assign crc_ctl.action = action_t'(s1_action_r);

  prcc_crc_unit u_crc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (crc_ctl),
    .data_byte (s1_data_r),
    .crc_q     (crc_q)
  );

  // Compare and output register
  logic            finish_fire;
  logic            ver_ok;
  logic            c_ok;
  logic [CrcW-1:0] out_crc_r;
  logic            out_ver_ok_r;
  logic            out_crc_ok_r;
  logic            out_rec_ok_r;

  assign finish_fire = s1_fire && s1_is_finish;
  assign ver_ok      = (s1_ver_r == exp_version_r);
  assign c_ok        = (s1_crc_r == crc_q);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      out_crc_r    <= crc_q;
      out_ver_ok_r <= ver_ok;
      out_crc_ok_r <= c_ok;
      out_rec_ok_r <= (ver_ok && c_ok) || bypass_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_crc_value    = out_crc_r;
  assign out_version_ok   = out_ver_ok_r;
  assign out_crc_ok       = out_crc_ok_r;
  assign out_record_valid = out_rec_ok_r;

  // Checks
  `PRCC_ASSERT_NEXT(a_preset_after_finish, finish_fire, crc_q == CRC_PRESET, "CRC not preset after finish")
  `PRCC_ASSERT_SAME(a_result_from_finish, $rose(out_valid_r), $past(finish_fire), "result without finish")
  `PRCC_ASSERT_SAME(a_valid_flag, out_valid_r, out_rec_ok_r == ((out_ver_ok_r && out_crc_ok_r) || bypass_r), "record_valid inconsistent")
  `PRCC_ASSERT_SAME(a_ready_when_empty, !s1_valid_r, in_ready, "input stalled while stage empty")

endmodule

FILE: tb/sv/param_record_crc32_check_tb.sv
// Testbench for the settings record CRC-32/MPEG-2 check: directed, stall and random traffic.
`timescale 1ns / 100ps
module param_record_crc32_check_tb;
  import prcc_pkg::*;

  localparam logic [31:0] REC_POLY      = 32'h04C1_1DB7;
  localparam logic [31:0] REC_PRESET    = 32'hFFFF_FFFF;
  localparam logic [31:0] CHECK_123456789 = 32'h0376_E6E7;
  localparam logic [1:0]  ACT_UNUSED    = 2'd3;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          CYCLE_LIMIT   = 200000;

  // One expected result word
  typedef struct packed {
    logic [CrcW-1:0] crc_value;
    logic            version_ok;
    logic            crc_ok;
    logic            record_valid;
  } record_report_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_action = ACT_CLEAR;
  logic [ByteW-1:0]    in_data_byte = '0;
  logic [CrcW-1:0]     in_stored_crc = '0;
  logic [VersionW-1:0] in_stored_version = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CrcW-1:0]     out_crc_value;
  logic                out_version_ok;
  logic                out_crc_ok;
  logic                out_record_valid;
  logic                cfg_we = 1'b0;
  logic                cfg_index = CFG_EXPECTED_VERSION;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // Predictor state: CRC register and register copies
  logic [31:0]         model_crc = REC_PRESET;
  logic [15:0]         model_version = '0;
  logic                model_bypass = 1'b0;
  record_report_t      pending_reports[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int words_sent = 0;
  int fail_count = 0;
  int cycle_count = 0;

  param_record_crc32_check DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_data_byte      (in_data_byte),
    .in_stored_crc     (in_stored_crc),
    .in_stored_version (in_stored_version),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_crc_value     (out_crc_value),
    .out_version_ok    (out_version_ok),
    .out_crc_ok        (out_crc_ok),
    .out_record_valid  (out_record_valid),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side ready: long hold-off when requested, else random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result word against the oldest expectation
  always @(posedge clk) begin : check_results
    record_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result word: crc_value %h", out_crc_value);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_crc_value !== want.crc_value) begin
          $error("crc_value: expected %h, actual %h", want.crc_value, out_crc_value);
          fail_count++;
        end
        if (out_version_ok !== want.version_ok) begin
          $error("version_ok: expected %b, actual %b", want.version_ok, out_version_ok);
          fail_count++;
        end
        if (out_crc_ok !== want.crc_ok) begin
          $error("crc_ok: expected %b, actual %b", want.crc_ok, out_crc_ok);
          fail_count++;
        end
        if (out_record_valid !== want.record_valid) begin
          $error("record_valid: expected %b, actual %b", want.record_valid, out_record_valid);
          fail_count++;
        end
      end
    end
  end

  // MSB-first CRC-32/MPEG-2, one data bit per step
  function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc,
                                                input logic [7:0] data);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[31] ^ data[i];
      c  = {c[30:0], 1'b0} ^ (fb ? REC_POLY : 32'h0);
    end
    return c;
  endfunction

  // Advance the predictor by one accepted word
  function automatic void predict_record_word(input logic [1:0] action,
                                              input logic [7:0] data,
                                              input logic [31:0] scrc,
                                              input logic [15:0] sver);
    record_report_t rep;
    case (action)
      ACT_CLEAR: begin
        model_crc = REC_PRESET;
      end
      ACT_ABSORB: begin
        model_crc = crc_fold_byte(model_crc, data);
      end
      ACT_FINISH: begin
        rep.crc_value    = model_crc;
        rep.version_ok   = (sver == model_version);
        rep.crc_ok       = (scrc == model_crc);
        rep.record_valid = (rep.version_ok && rep.crc_ok) || model_bypass;
        pending_reports.push_back(rep);
        model_crc = REC_PRESET;
      end
      default: begin
      end
    endcase
  endfunction

  // Offer one word, hold it until accepted, then predict
  task automatic send_word(input logic [1:0] action, input logic [7:0] data,
                           input logic [31:0] scrc, input logic [15:0] sver);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= action;
    in_data_byte      <= data;
    in_stored_crc     <= scrc;
    in_stored_version <= sver;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_record_word(action, data, scrc, sver);
    if (action != ACT_UNUSED) words_sent++;
  endtask

  task automatic clear_crc();
    send_word(ACT_CLEAR, 8'($urandom), $urandom(), 16'($urandom));
  endtask

  task automatic absorb_byte(input logic [7:0] data);
    send_word(ACT_ABSORB, data, $urandom(), 16'($urandom));
  endtask

  task automatic finish_record(input logic [31:0] scrc, input logic [15:0] sver);
    send_word(ACT_FINISH, 8'($urandom), scrc, sver);
  endtask

  task automatic send_unused();
    send_word(ACT_UNUSED, 8'($urandom), $urandom(), 16'($urandom));
  endtask

  task automatic send_noise_word();
    send_word(2'($urandom_range(3)), 8'($urandom), $urandom(), 16'($urandom));
  endtask

  // Stop offering, wait for every result, then let clear/absorb words settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers; only call when drained
  task automatic set_config(input logic [15:0] ver, input logic byp);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EXPECTED_VERSION;
    cfg_wdata <= ver;
    @(posedge clk);
    cfg_index <= CFG_BYPASS_CHECK;
    cfg_wdata <= {15'($urandom), byp};
    @(posedge clk);
    cfg_we <= 1'b0;
    model_version = ver;
    model_bypass  = byp;
    @(posedge clk);
  endtask

  // Well-formed record: optional clear, bytes, finish with often matching fields
  task automatic send_random_record();
    int          nbytes;
    logic [31:0] scrc;
    logic [15:0] sver;
    if ($urandom_range(3) == 0) clear_crc();
    nbytes = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
    repeat (nbytes) begin
      if ($urandom_range(19) == 0) send_unused();
      absorb_byte(8'($urandom));
    end
    case ($urandom_range(3))
      0:       scrc = $urandom();
      1:       scrc = model_crc ^ (32'h1 << $urandom_range(31));
      default: scrc = model_crc;
    endcase
    case ($urandom_range(4))
      0:       sver = 16'($urandom);
      1:       sver = model_version ^ (16'h1 << $urandom_range(15));
      default: sver = model_version;
    endcase
    finish_record(scrc, sver);
  endtask

  // Extremes, every action, known check value, unused code, empty record
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    finish_record(REC_PRESET, 16'h0000);          // empty record: preset CRC
    for (int i = 1; i <= 9; i++) absorb_byte(8'h30 + 8'(i));
    finish_record(CHECK_123456789, 16'h0000);     // standard check string
    absorb_byte(8'h00);
    absorb_byte(8'hFF);
    send_unused();
    clear_crc();
    absorb_byte(8'hFF);
    finish_record(32'h0000_0000, 16'hFFFF);       // both mismatch
    absorb_byte(8'h80);
    finish_record(model_crc, 16'hFFFF);           // CRC good, version bad
    absorb_byte(8'h5A);
    finish_record(~model_crc, 16'h0000);          // version good, CRC bad
    send_unused();
    finish_record(32'hFFFF_FFFF, 16'h0000);       // unused code leaves preset
    drain_results();
  endtask

  // Register extremes, bypass on with bad records
  task automatic test_config_extremes();
    set_config(16'hFFFF, 1'b0);
    repeat (5) send_random_record();
    absorb_byte(8'hC3);
    finish_record(model_crc, 16'hFFFF);
    drain_results();
    set_config(16'h0000, 1'b1);
    absorb_byte(8'h3C);
    finish_record(~model_crc, 16'h1234);          // bypass forces valid
    repeat (5) send_random_record();
    drain_results();
    set_config(16'hFFFF, 1'b1);
    repeat (4) send_random_record();
    drain_results();
  endtask

  // Long result stall while the sender keeps offering, then a full pause
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_results();
    set_config(16'($urandom), 1'b0);
    hold_left = 150;
    repeat (12) begin
      absorb_byte(8'($urandom));
      finish_record(model_crc, model_version);
    end
    drain_results();
    repeat (4) send_random_record();
    drain_results();
  endtask

  // Mostly well-formed records with some noise, config changed halfway
  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    int target;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int half = 0; half < 2; half++) begin
      drain_results();
      set_config(16'($urandom), ($urandom_range(3) == 0));
      target = words_sent + count / 2;
      while (words_sent < target) begin
        if ($urandom_range(9) < 8) send_random_record();
        else send_noise_word();
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_extremes();
    test_random_traffic(160, 32, 45);
    test_output_stall();
    test_random_traffic(150, 45, 32);
    test_random_traffic(150, 0, 0);
    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
